[sv/bba_pkg.sv]
`default_nettype none
package bba_pkg;

	localparam int HEAP_LOG2      = 16;
	localparam int MIN_BLOCK_LOG2 = 4;
	localparam int HEADER_BYTES   = 32;

	localparam int UNIT_W      = HEAP_LOG2 - MIN_BLOCK_LOG2;
	localparam int ORDER_CAP   = 26;
	localparam int TOP_ORDER   = (UNIT_W < ORDER_CAP) ? UNIT_W : ORDER_CAP;
	localparam int ORDER_COUNT = TOP_ORDER + 1;
	localparam int HIDX_W      = $clog2(ORDER_COUNT);
	localparam int ORD_W       = 5;
	localparam int META_W      = ORD_W + 1;

	localparam logic [31:0] BASE_RESET = 32'h0060_0000;
	localparam logic        KIND_ALLOC = 1'b0;
	localparam logic        KIND_FREE  = 1'b1;

	typedef logic [UNIT_W-1:0] unit_t;
	typedef logic [ORD_W-1:0]  ord_t;

	typedef struct packed {
		ord_t order;
		logic free;
	} meta_t;

	// memory requests from the sequencer to the unit tables
	typedef struct packed {
		logic  meta_we;
		unit_t meta_wa;
		meta_t meta_wd;
		unit_t meta_ra;
		logic  next_we;
		unit_t next_wa;
		unit_t next_wd;
		logic  prev_we;
		unit_t prev_wa;
		unit_t prev_wd;
		unit_t link_ra;
	} mem_req_t;

	typedef enum logic [4:0] {
		ST_INIT,
		ST_IDLE,
		ST_A_CHECK,
		ST_A_SEARCH,
		ST_A_RDLINK,
		ST_A_UNLINK,
		ST_A_SPLIT,
		ST_F_CHECK,
		ST_F_META,
		ST_F_BUDDY,
		ST_F_BCHK,
		ST_F_UNLINK,
		ST_F_MERGE,
		ST_P_READ,
		ST_P_WR1,
		ST_P_WR2,
		ST_FIN
	} state_t;

	// number of significant bits of v: smallest order whose block covers it
	function automatic ord_t bit_len(input unit_t v);
		ord_t r;
		r = '0;
		for (int i = 0; i < UNIT_W; i++) begin
			if (v[i]) begin
				r = ORD_W'(i + 1);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[sv/bba_ram.sv]
`default_nettype none
module bba_ram import bba_pkg::*; #(
	parameter int WIDTH = 12
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire unit_t            wa,
	input  wire logic [WIDTH-1:0] wd,
	input  wire unit_t            ra,
	output logic [WIDTH-1:0]      rd
);

	logic [WIDTH-1:0] mem [2**UNIT_W];

	// one write, one registered read (old data on same-address collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd <= mem[ra];
	end

endmodule
`default_nettype wire

[sv/bba_seq.sv]
`default_nettype none
module bba_seq import bba_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        kind,
	input  wire logic [31:0] size,
	input  wire logic [31:0] addr,
	input  wire logic [31:0] base,
	input  wire meta_t       rd_meta,
	input  wire unit_t       rd_next,
	input  wire unit_t       rd_prev,
	input  wire logic        res_take,
	output mem_req_t         mreq,
	output logic             idle,
	output logic             done,
	output logic             res_ok,
	output logic [31:0]      res_addr
);

	state_t state_q, state_d;

	logic              kind_q;
	logic [31:0]       size_q;
	logic [31:0]       addr_q;
	ord_t              o_q;
	ord_t              need_q;
	unit_t             u_q;
	unit_t             b_q;
	unit_t             t_q;
	logic              ok_q;
	logic [31:0]       gaddr_q;
	logic              head_valid_q [ORDER_COUNT];
	unit_t             head_unit_q  [ORDER_COUNT];

	logic [HIDX_W-1:0] hi;
	logic              hv;
	unit_t             hu;
	unit_t             bit_o;
	unit_t             buddy;
	ord_t              o_dec;
	unit_t             split_b;
	unit_t             merged_u;
	ord_t              o_inc;
	logic [32:0]       real_sz;
	logic [32:0]       real_m1;
	logic              too_big;
	ord_t              need;
	logic [31:0]       off;
	logic              off_bad;
	unit_t             off_u;
	unit_t             amask;
	logic              meta_bad;
	logic [31:0]       grant;

	logic              head_we;
	logic [HIDX_W-1:0] head_wi;
	logic              head_wv;
	unit_t             head_wu;

	// shared helpers
	assign hi       = o_q[HIDX_W-1:0];
	assign hv       = head_valid_q[hi];
	assign hu       = head_unit_q[hi];
	assign bit_o    = unit_t'(1) << o_q;
	assign buddy    = u_q ^ bit_o;
	assign o_dec    = o_q - ORD_W'(1);
	assign split_b  = u_q ^ (unit_t'(1) << o_dec);
	assign merged_u = u_q & ~bit_o;
	assign o_inc    = o_q + ORD_W'(1);
	assign real_sz  = {1'b0, size_q} + 33'(HEADER_BYTES);
	assign real_m1  = real_sz - 33'd1;
	assign too_big  = real_sz > (33'd1 << HEAP_LOG2);
	assign need     = bit_len(real_m1[HEAP_LOG2-1:MIN_BLOCK_LOG2]);
	assign off      = addr_q - base - 32'(HEADER_BYTES);
	assign off_bad  = ((off >> HEAP_LOG2) != 32'd0) || (off[MIN_BLOCK_LOG2-1:0] != '0);
	assign off_u    = off[HEAP_LOG2-1:MIN_BLOCK_LOG2];
	assign amask    = (unit_t'(1) << rd_meta.order) - unit_t'(1);
	assign meta_bad = rd_meta.free || (rd_meta.order > ORD_W'(TOP_ORDER))
		|| ((u_q & amask) != '0);
	assign grant    = base + (32'(u_q) << MIN_BLOCK_LOG2) + 32'(HEADER_BYTES);

	assign idle     = (state_q == ST_IDLE);
	assign done     = (state_q == ST_FIN);
	assign res_ok   = ok_q;
	assign res_addr = gaddr_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT:     state_d = ST_IDLE;
			ST_IDLE:     if (start) begin
				state_d = (kind == KIND_FREE) ? ST_F_CHECK : ST_A_CHECK;
			end
			ST_A_CHECK:  state_d = (size_q == 32'd0 || too_big
				|| need > ORD_W'(TOP_ORDER)) ? ST_FIN : ST_A_SEARCH;
			ST_A_SEARCH: begin
				if (o_q > ORD_W'(TOP_ORDER)) begin
					state_d = ST_FIN;
				end else if (hv) begin
					state_d = ST_A_RDLINK;
				end
			end
			ST_A_RDLINK: state_d = ST_A_UNLINK;
			ST_A_UNLINK: state_d = ST_A_SPLIT;
			ST_A_SPLIT:  if (o_q <= need_q) begin
				state_d = ST_FIN;
			end
			ST_F_CHECK:  state_d = (addr_q == 32'd0 || off_bad) ? ST_FIN : ST_F_META;
			ST_F_META:   state_d = meta_bad ? ST_FIN : ST_F_BUDDY;
			ST_F_BUDDY:  state_d = (o_q < ORD_W'(TOP_ORDER)) ? ST_F_BCHK : ST_P_READ;
			ST_F_BCHK:   state_d = (rd_meta.order == o_q && rd_meta.free)
				? ST_F_UNLINK : ST_P_READ;
			ST_F_UNLINK: state_d = ST_F_MERGE;
			ST_F_MERGE:  state_d = ST_F_BUDDY;
			ST_P_READ:   state_d = hv ? ST_P_WR1 : ST_FIN;
			ST_P_WR1:    state_d = ST_P_WR2;
			ST_P_WR2:    state_d = ST_FIN;
			ST_FIN:      if (res_take) begin
				state_d = ST_IDLE;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// memory and list-head requests
	always_comb begin
		mreq    = '0;
		head_we = 1'b0;
		head_wi = hi;
		head_wv = 1'b1;
		head_wu = u_q;
		unique case (state_q)
			ST_INIT: begin
				mreq.meta_we = 1'b1;
				mreq.meta_wa = '0;
				mreq.meta_wd = '{order: ORD_W'(TOP_ORDER), free: 1'b1};
				mreq.next_we = 1'b1;
				mreq.next_wa = '0;
				mreq.next_wd = '0;
				mreq.prev_we = 1'b1;
				mreq.prev_wa = '0;
				mreq.prev_wd = '0;
			end
			ST_A_RDLINK: mreq.link_ra = u_q;
			ST_A_UNLINK: begin
				head_we = 1'b1;
				if (rd_next == u_q) begin
					head_wv = 1'b0;
				end else begin
					head_wu      = rd_next;
					mreq.next_we = 1'b1;
					mreq.next_wa = rd_prev;
					mreq.next_wd = rd_next;
					mreq.prev_we = 1'b1;
					mreq.prev_wa = rd_next;
					mreq.prev_wd = rd_prev;
				end
			end
			ST_A_SPLIT: begin
				mreq.meta_we = 1'b1;
				if (o_q > need_q) begin
					// upper half goes onto the empty list one order down
					mreq.meta_wa = split_b;
					mreq.meta_wd = '{order: o_dec, free: 1'b1};
					mreq.next_we = 1'b1;
					mreq.next_wa = split_b;
					mreq.next_wd = split_b;
					mreq.prev_we = 1'b1;
					mreq.prev_wa = split_b;
					mreq.prev_wd = split_b;
					head_we      = 1'b1;
					head_wi      = o_dec[HIDX_W-1:0];
					head_wu      = split_b;
				end else begin
					mreq.meta_wa = u_q;
					mreq.meta_wd = '{order: o_q, free: 1'b0};
				end
			end
			ST_F_CHECK:  mreq.meta_ra = off_u;
			ST_F_META: begin
				mreq.meta_we = !meta_bad;
				mreq.meta_wa = u_q;
				mreq.meta_wd = '{order: rd_meta.order, free: 1'b1};
			end
			ST_F_BUDDY:  mreq.meta_ra = buddy;
			ST_F_BCHK:   mreq.link_ra = b_q;
			ST_F_UNLINK: begin
				if (hv && hu == b_q && rd_next == b_q) begin
					head_we = 1'b1;
					head_wv = 1'b0;
				end else begin
					head_we      = hv && hu == b_q;
					head_wu      = rd_next;
					mreq.next_we = 1'b1;
					mreq.next_wa = rd_prev;
					mreq.next_wd = rd_next;
					mreq.prev_we = 1'b1;
					mreq.prev_wa = rd_next;
					mreq.prev_wd = rd_prev;
				end
			end
			ST_F_MERGE: begin
				mreq.meta_we = 1'b1;
				mreq.meta_wa = merged_u;
				mreq.meta_wd = '{order: o_inc, free: 1'b1};
			end
			ST_P_READ: begin
				mreq.link_ra = hu;
				if (!hv) begin
					mreq.next_we = 1'b1;
					mreq.next_wa = u_q;
					mreq.next_wd = u_q;
					mreq.prev_we = 1'b1;
					mreq.prev_wa = u_q;
					mreq.prev_wd = u_q;
					head_we      = 1'b1;
				end
			end
			ST_P_WR1: begin
				mreq.next_we = 1'b1;
				mreq.next_wa = u_q;
				mreq.next_wd = hu;
				mreq.prev_we = 1'b1;
				mreq.prev_wa = u_q;
				mreq.prev_wd = rd_prev;
			end
			ST_P_WR2: begin
				mreq.next_we = 1'b1;
				mreq.next_wa = t_q;
				mreq.next_wd = u_q;
				mreq.prev_we = 1'b1;
				mreq.prev_wa = hu;
				mreq.prev_wd = u_q;
				head_we      = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// state and list heads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			for (int i = 0; i < ORDER_COUNT; i++) begin
				head_valid_q[i] <= (i == TOP_ORDER);
				head_unit_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (head_we) begin
				head_valid_q[head_wi] <= head_wv;
				head_unit_q[head_wi]  <= head_wu;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				kind_q  <= kind;
				size_q  <= size;
				addr_q  <= addr;
				ok_q    <= 1'b0;
				gaddr_q <= '0;
			end
			ST_A_CHECK: begin
				need_q <= need;
				o_q    <= need;
			end
			ST_A_SEARCH: begin
				u_q <= hu;
				if (!hv) begin
					o_q <= o_inc;
				end
			end
			ST_A_SPLIT: begin
				if (o_q > need_q) begin
					o_q <= o_dec;
				end else begin
					ok_q    <= 1'b1;
					gaddr_q <= grant;
				end
			end
			ST_F_CHECK: begin
				u_q  <= off_u;
				ok_q <= (addr_q == 32'd0);
			end
			ST_F_META:  o_q <= rd_meta.order;
			ST_F_BUDDY: b_q <= buddy;
			ST_F_MERGE: begin
				u_q <= merged_u;
				o_q <= o_inc;
			end
			ST_P_READ:  ok_q <= !hv;
			ST_P_WR1:   t_q <= rd_prev;
			ST_P_WR2:   ok_q <= 1'b1;
			default: begin
			end
		endcase
	end

	// a split never goes below the order that was asked for
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_A_SPLIT) |-> (o_q >= need_q))
		else $error("split below needed order");

	// merging stops at the top order
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_F_BUDDY) |-> (o_q <= ORD_W'(TOP_ORDER)))
		else $error("merge past top order");

	// a finished free never reports an address
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && kind_q == KIND_FREE) |-> (gaddr_q == 32'd0))
		else $error("free with nonzero address");

	// a result is held until it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && !res_take) |=> (state_q == ST_FIN))
		else $error("result dropped");

endmodule
`default_nettype wire

[sv/buddy_block_allocator_unit.sv]
// Buddy allocator, one request at a time through a small sequencer and three unit tables
// (order/free, next link, prev link), each with one write and one registered read port.
// Allocate searches upward past empty orders, then splits down to the needed order; free
// merges with free buddies up to the top order, then puts the block onto its list.
// A new request is taken once the result has moved into the output register; reset seeds
// the top-order block.
`default_nettype none
module buddy_block_allocator_unit import bba_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // request_bytes[31:0], release_address[63:32]
	input  wire logic [0:0]  s_tuser,   // kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // granted_address
	output logic [0:0]       m_tuser,   // ok
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data
);

	logic [31:0] base_q;
	mem_req_t    mreq;
	meta_t       rd_meta;
	logic [META_W-1:0] rd_meta_raw;
	unit_t       rd_next;
	unit_t       rd_prev;
	logic        idle;
	logic        done;
	logic        res_ok;
	logic [31:0] res_addr;
	logic        res_take;
	logic        m_tvalid_q;
	logic        ok_q;
	logic [31:0] addr_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = idle;
	assign res_take  = !m_tvalid_q || m_tready;
	assign rd_meta   = meta_t'(rd_meta_raw);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = addr_q;
	assign m_tuser   = ok_q;

	// heap base register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= cfg_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (done && res_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && res_take) begin
			ok_q   <= res_ok;
			addr_q <= res_addr;
		end
	end

	bba_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (s_tvalid && s_tready),
		.kind     (s_tuser[0]),
		.size     (s_tdata[31:0]),
		.addr     (s_tdata[63:32]),
		.base     (base_q),
		.rd_meta  (rd_meta),
		.rd_next  (rd_next),
		.rd_prev  (rd_prev),
		.res_take (res_take),
		.mreq     (mreq),
		.idle     (idle),
		.done     (done),
		.res_ok   (res_ok),
		.res_addr (res_addr)
	);

	bba_ram #(.WIDTH(META_W)) u_meta (
		.clk (clk),
		.we  (mreq.meta_we),
		.wa  (mreq.meta_wa),
		.wd  (mreq.meta_wd),
		.ra  (mreq.meta_ra),
		.rd  (rd_meta_raw)
	);

	bba_ram #(.WIDTH(UNIT_W)) u_next (
		.clk (clk),
		.we  (mreq.next_we),
		.wa  (mreq.next_wa),
		.wd  (mreq.next_wd),
		.ra  (mreq.link_ra),
		.rd  (rd_next)
	);

	bba_ram #(.WIDTH(UNIT_W)) u_prev (
		.clk (clk),
		.we  (mreq.prev_we),
		.wa  (mreq.prev_wa),
		.wd  (mreq.prev_wd),
		.ra  (mreq.link_ra),
		.rd  (rd_prev)
	);

endmodule
`default_nettype wire
